@@ hdl/wbps_pkg.sv @@
// Shared constants and types for the wildcard byte pattern scanner.
// Used by wbps_match and by the top level wildcard_byte_pattern_scan.
// No dependencies.
package wbps_pkg;

    localparam int DEF_MAX_PATTERN_BYTES = 16;
    localparam int DEF_COUNT_BITS        = 32;

    localparam int ADDR_BITS      = 64;
    localparam int PAT_WORD_BITS  = 64;
    localparam int MASK_BITS      = 16;
    localparam int LEN_BITS       = 5;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;

    typedef logic [7:0] byte_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_HIGH = 3'd1,
        REG_WILDCARD     = 3'd2,
        REG_LENGTH       = 3'd3,
        REG_RANGE_START  = 3'd4
    } cfg_reg_t;

endpackage

@@ hdl/wildcard_byte_pattern_scan.sv @@
// Wildcard byte pattern scanner: finds the first match of a masked byte pattern in a byte stream.
// The accepting edge loads the window stage; the result register is loaded from that stage
// when it can advance. Throughput: one byte per cycle unless out_stall holds a waiting result;
// the output register then still lets a byte enter the empty window stage.
// Reset clears the window, the byte count, the match flag and all valid bits, and loads the
// registers with their defaults: pattern zero, no wildcards, length 1, range start 0.
module wildcard_byte_pattern_scan
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
    parameter int COUNT_BITS        = DEF_COUNT_BITS
)
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                data_byte,
    input  logic                      last_byte,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [ADDR_BITS-1:0]      match_address
);

    // Configuration registers.
    logic [PAT_WORD_BITS-1:0] pattern_low_reg;
    logic [PAT_WORD_BITS-1:0] pattern_high_reg;
    logic [MASK_BITS-1:0]     wildcard_mask_reg;
    logic [LEN_BITS-1:0]      pattern_length_reg;
    logic [ADDR_BITS-1:0]     range_start_reg;

    // Running scan state.
    byte_t [MAX_PATTERN_BYTES-1:0] window_reg;
    byte_t [MAX_PATTERN_BYTES-1:0] window_next;
    logic  [COUNT_BITS-1:0]        count_reg;
    logic  [COUNT_BITS-1:0]        count_next;
    logic                          match_reported_reg;

    // Window stage: a snapshot of the state after the accepted byte.
    logic                          s1_valid_reg;
    logic                          s1_last_reg;
    byte_t [MAX_PATTERN_BYTES-1:0] s1_window_reg;
    logic  [COUNT_BITS-1:0]        s1_count_reg;

    // Result register.
    logic                          out_valid_reg;
    logic                          found_reg;
    logic  [ADDR_BITS-1:0]         address_reg;

    logic                          advance;
    logic                          accept;
    logic  [LEN_BITS-1:0]          used_length;
    logic                          window_hit;
    logic                          count_ok;
    logic                          report_hit;
    logic                          report_miss;
    logic  [COUNT_BITS-1:0]        offset;
    logic  [ADDR_BITS-1:0]         hit_address;
    logic  [2*PAT_WORD_BITS-1:0]   pattern_all;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            wildcard_mask_reg  <= '0;
            pattern_length_reg <= LEN_BITS'(1);
            range_start_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATTERN_LOW:  pattern_low_reg    <= cfg_data;
                REG_PATTERN_HIGH: pattern_high_reg   <= cfg_data;
                REG_WILDCARD:     wildcard_mask_reg  <= cfg_data[MASK_BITS-1:0];
                REG_LENGTH:       pattern_length_reg <= cfg_data[LEN_BITS-1:0];
                REG_RANGE_START:  range_start_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Entry 0 holds the newest byte; the count saturates.
    always_comb
    begin
        window_next[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN_BYTES; k++)
        begin
            window_next[k] = window_reg[k-1];
        end
        count_next = (count_reg == '1) ? count_reg : count_reg + COUNT_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            count_reg    <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                // The byte marked last closes the range; the next byte starts fresh.
                if (last_byte)
                begin
                    window_reg <= '0;
                    count_reg  <= '0;
                end
                else
                begin
                    window_reg <= window_next;
                    count_reg  <= count_next;
                end
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg   <= last_byte;
            s1_window_reg <= window_next;
            s1_count_reg  <= count_next;
        end
    end

    // Out-of-range lengths clamp to 1 .. MAX_PATTERN_BYTES.
    always_comb
    begin
        if (pattern_length_reg == '0)
        begin
            used_length = LEN_BITS'(1);
        end
        else if (pattern_length_reg > LEN_BITS'(MAX_PATTERN_BYTES))
        begin
            used_length = LEN_BITS'(MAX_PATTERN_BYTES);
        end
        else
        begin
            used_length = pattern_length_reg;
        end
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};

    wbps_match #(
        .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
    ) u_match (
        .window        (s1_window_reg),
        .pattern       (pattern_all[8*MAX_PATTERN_BYTES-1:0]),
        .wildcard_bits (wildcard_mask_reg[MAX_PATTERN_BYTES-1:0]),
        .length        (used_length),
        .hit           (window_hit)
    );

    assign count_ok    = s1_count_reg >= COUNT_BITS'(used_length);
    assign offset      = s1_count_reg - COUNT_BITS'(used_length);
    assign hit_address = range_start_reg + ADDR_BITS'(offset);
    assign report_hit  = !match_reported_reg && count_ok && window_hit;
    assign report_miss = !match_reported_reg && !report_hit && s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reported_reg <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && (report_hit || report_miss);
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    match_reported_reg <= 1'b0;
                end
                else if (report_hit)
                begin
                    match_reported_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            found_reg   <= report_hit;
            address_reg <= report_hit ? hit_address : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = address_reg;

    // A not-found result always carries a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_address == '0)
        else $error("not-found result with nonzero address");

    // Closing a range clears the running window state.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> count_reg == '0 && window_reg == '0)
        else $error("range end did not clear the window");

    // A reported match blocks further results until the range ends.
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && report_hit && !s1_last_reg |=> match_reported_reg)
        else $error("match flag not set after a reported match");

    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && s1_last_reg |=> !match_reported_reg)
        else $error("match flag not cleared at range end");

    // The input side is held back only when the window stage cannot drain.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without back pressure");

endmodule

@@ hdl/wbps_match.sv @@
// Window compare for the wildcard byte pattern scanner.
// Compares the newest window bytes with the pattern under the wildcard mask.
// Depends on wbps_pkg.
module wbps_match
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES
)
(
    input  byte_t [MAX_PATTERN_BYTES-1:0] window,
    input  byte_t [MAX_PATTERN_BYTES-1:0] pattern,
    input  logic  [MAX_PATTERN_BYTES-1:0] wildcard_bits,
    input  logic  [LEN_BITS-1:0]          length,
    output logic                          hit
);

    localparam int IDX_BITS = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    // Pattern byte i lines up with the window byte that arrived length-1-i bytes ago.
    always_comb
    begin
        logic [LEN_BITS-1:0] pos;
        logic [IDX_BITS-1:0] idx;
        hit = 1'b1;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            pos = length - LEN_BITS'(i) - LEN_BITS'(1);
            idx = pos[IDX_BITS-1:0];
            if ((LEN_BITS'(i) < length) && !wildcard_bits[i] && (window[idx] != pattern[i]))
            begin
                hit = 1'b0;
            end
        end
    end

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for wildcard_byte_pattern_scan: directed table, then random phases.
// Expected results come from a behavioral scanner kept inside this module.
// Depends on wbps_pkg and the RTL of wildcard_byte_pattern_scan.
module tb;
    import wbps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXB            = DEF_MAX_PATTERN_BYTES;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_CYCLES     = 300;
    localparam int QUIET_LIMIT     = 2000;
    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 42;

    typedef enum logic [1:0] {
        CHECK_PREDICT,
        CHECK_NONE,
        CHECK_RESULT
    } row_check_t;

    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] addr;
    } scan_result_t;

    typedef struct packed {
        logic                     is_write;
        cfg_reg_t                 reg_sel;
        logic [CFG_DATA_BITS-1:0] value;
        byte_t                    data;
        logic                     last;
        row_check_t               check;
        scan_result_t             typed;
    } stim_row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_stall;
    byte_t                     data_byte;
    logic                      last_byte;
    logic                      out_valid;
    logic                      out_stall;
    logic                      found;
    logic [ADDR_BITS-1:0]      match_address;

    // Register shadows and scan state of the behavioral scanner.
    logic [63:0]               pat_low;
    logic [63:0]               pat_high;
    logic [15:0]               wild_mask;
    logic [4:0]                pat_len;
    logic [ADDR_BITS-1:0]      base_addr;
    byte_t                     window_bytes [MAXB];
    logic [DEF_COUNT_BITS-1:0] range_count;
    logic                      range_matched;

    scan_result_t pending_results [$];
    scan_result_t want;
    stim_row_t    directed_rows [$];
    stim_row_t    row;

    int fail_count;
    int quiet_cycles;
    int burst_left;
    int items_sent;
    bit hold_request;

    wildcard_byte_pattern_scan DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_address (match_address)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int used_len();
        if (pat_len == 0)
            return 1;
        if (pat_len > MAXB)
            return MAXB;
        return int'(pat_len);
    endfunction

    function automatic byte_t pattern_at(input int i);
        if (i < 8)
            return pat_low[i*8 +: 8];
        return pat_high[(i-8)*8 +: 8];
    endfunction

    task automatic clear_window();
        int k;
        for (k = 0; k < MAXB; k++)
            window_bytes[k] = '0;
        range_count   = '0;
        range_matched = 1'b0;
    endtask

    // One accepted word through the scanner; the oldest byte of a candidate is compared
    // against pattern byte 0.
    task automatic scan_step(input byte_t d, input logic l, output logic has,
                             output scan_result_t res);
        int                   eff;
        int                   k;
        bit                   hit;
        logic [ADDR_BITS-1:0] offset;
        eff = used_len();
        for (k = MAXB - 1; k > 0; k--)
            window_bytes[k] = window_bytes[k-1];
        window_bytes[0] = d;
        if (range_count != '1)
            range_count = range_count + 1'b1;
        hit = 1'b1;
        for (k = 0; k < eff; k++)
        begin
            if (!wild_mask[k] && window_bytes[eff-1-k] != pattern_at(k))
                hit = 1'b0;
        end
        has = 1'b0;
        res = '0;
        if (!range_matched && range_count >= eff && hit)
        begin
            range_matched = 1'b1;
            offset        = range_count;
            offset        = offset - eff;
            has           = 1'b1;
            res.found     = 1'b1;
            res.addr      = base_addr + offset;
        end
        else if (l && !range_matched)
        begin
            has = 1'b1;
        end
        if (l)
            clear_window();
    endtask

    task automatic note_mismatch(input string what, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        fail_count++;
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, exp_val, act_val);
    endtask

    // Offers one word; the sender works in bursts with random gaps between them.
    task automatic send_byte(input byte_t d, input logic l, input row_check_t chk,
                             input scan_result_t typed);
        int           gap;
        logic         has;
        scan_result_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        data_byte <= d;
        last_byte <= l;
        do @(posedge clk); while (in_stall);
        burst_left--;
        scan_step(d, l, has, predicted);
        case (chk)
            CHECK_PREDICT: if (has) pending_results.push_back(predicted);
            CHECK_RESULT:  pending_results.push_back(typed);
            default:       ;
        endcase
    endtask

    // Brings the block to rest: no word offered, no result owed, pipeline drained.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        case (r)
            REG_PATTERN_LOW:  pat_low   = v;
            REG_PATTERN_HIGH: pat_high  = v;
            REG_WILDCARD:     wild_mask = v[15:0];
            REG_LENGTH:       pat_len   = v[4:0];
            REG_RANGE_START:  base_addr = v;
            default:          ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic add_write(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] v);
        stim_row_t w;
        w          = '0;
        w.is_write = 1'b1;
        w.reg_sel  = r;
        w.value    = v;
        directed_rows.push_back(w);
    endtask

    task automatic add_byte(input byte_t d, input logic l, input row_check_t chk,
                            input logic f, input logic [ADDR_BITS-1:0] a);
        stim_row_t b;
        b             = '0;
        b.data        = d;
        b.last        = l;
        b.check       = chk;
        b.typed.found = f;
        b.typed.addr  = a;
        directed_rows.push_back(b);
    endtask

    // One range: mostly a planted copy of the pattern in random filler, some with a
    // corrupted byte, the rest plain noise drawn partly from the pattern bytes.
    task automatic send_range();
        byte_t range_bytes [64];
        int    rlen;
        int    eff;
        int    spot;
        int    kind;
        int    j;
        int    k;
        eff  = used_len();
        kind = $urandom_range(0, 9);
        rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
        if (kind < 8 && rlen < eff)
            rlen = eff + $urandom_range(0, 8);
        for (k = 0; k < rlen; k++)
        begin
            if ($urandom_range(0, 1) == 1)
                range_bytes[k] = byte_t'($urandom_range(0, 255));
            else
                range_bytes[k] = pattern_at($urandom_range(0, eff - 1));
        end
        if (kind < 8)
        begin
            spot = $urandom_range(0, rlen - eff);
            for (k = 0; k < eff; k++)
            begin
                if (!wild_mask[k])
                    range_bytes[spot+k] = pattern_at(k);
            end
            if (kind >= 6)
            begin
                j = $urandom_range(0, eff - 1);
                range_bytes[spot+j] = range_bytes[spot+j] ^ byte_t'($urandom_range(1, 255));
            end
        end
        for (k = 0; k < rlen; k++)
            send_byte(range_bytes[k], k == rlen - 1, CHECK_PREDICT, '0);
        items_sent += rlen;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t ns: result with none expected, got found=%b address %h",
                             $time, found, match_address);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (found !== want.found)
                        note_mismatch("found", want.found, found);
                    if (match_address !== want.addr)
                        note_mismatch("match_address", want.addr, match_address);
                end
            end
        end
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: stall pattern switches among random modes; once it holds off for a
    // long stretch so the block fills and pushes back on the sender.
    initial
    begin : receiver
        int mode;
        int mode_left;
        out_stall = 1'b0;
        mode      = 0;
        mode_left = 100;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(40, 200);
            end
            mode_left--;
            case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((mode_left % 7) < 3);
            endcase
        end
    end

    initial
    begin : stimulus
        int                   phase;
        int                   n;
        int                   phase_start;
        logic [15:0]          mask_val;
        logic [4:0]           len_val;
        logic [ADDR_BITS-1:0] start_val;
        logic [63:0]          low_val;
        logic [63:0]          high_val;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        data_byte  = '0;
        last_byte  = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = REG_PATTERN_LOW;
        cfg_data   = '0;
        burst_left = 0;
        items_sent = 0;
        pat_low    = '0;
        pat_high   = '0;
        wild_mask  = '0;
        pat_len    = 5'd1;
        base_addr  = '0;
        clear_window();

        // Reset defaults: one pattern byte of zero, no wildcards, range start zero.
        add_byte(8'h00, 1'b0, CHECK_RESULT, 1'b1, 64'h0);
        add_byte(8'hFF, 1'b1, CHECK_NONE,   1'b0, 64'h0);
        add_byte(8'hFF, 1'b1, CHECK_RESULT, 1'b0, 64'h0);
        add_byte(8'h5A, 1'b0, CHECK_NONE,   1'b0, 64'h0);
        add_byte(8'h00, 1'b1, CHECK_RESULT, 1'b1, 64'h1);
        // Length zero behaves as one; address at the top of the space and then wrapping.
        add_write(REG_LENGTH, 64'd0);
        add_write(REG_PATTERN_LOW, 64'hFF);
        add_write(REG_RANGE_START, 64'hFFFF_FFFF_FFFF_FFFF);
        add_byte(8'hFF, 1'b1, CHECK_RESULT, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        add_write(REG_RANGE_START, 64'hFFFF_FFFF_FFFF_FFFE);
        add_byte(8'h00, 1'b0, CHECK_NONE,   1'b0, 64'h0);
        add_byte(8'h00, 1'b0, CHECK_NONE,   1'b0, 64'h0);
        add_byte(8'hFF, 1'b1, CHECK_RESULT, 1'b1, 64'h0);
        // Oversized length acts as sixteen; first and last bytes are wildcards, and the
        // match completes on the final word of the range.
        add_write(REG_LENGTH, 64'd31);
        add_write(REG_PATTERN_LOW, 64'h0706_0504_0302_0100);
        add_write(REG_PATTERN_HIGH, 64'h0F0E_0D0C_0B0A_0908);
        add_write(REG_WILDCARD, 64'h8001);
        add_write(REG_RANGE_START, 64'h1000);
        add_byte(8'hAA, 1'b0, CHECK_PREDICT, 1'b0, 64'h0);
        for (n = 1; n < 15; n++)
            add_byte(byte_t'(n), 1'b0, CHECK_PREDICT, 1'b0, 64'h0);
        add_byte(8'h77, 1'b1, CHECK_RESULT, 1'b1, 64'h1000);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n])
        begin
            row = directed_rows[n];
            if (row.is_write)
            begin
                settle();
                write_reg(row.reg_sel, row.value);
            end
            else
            begin
                send_byte(row.data, row.last, row.check, row.typed);
            end
        end

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       len_val = 5'd1;
                1:       len_val = 5'd16;
                2:       len_val = 5'd0;
                3:       len_val = 5'd31;
                4:       len_val = 5'd2;
                5:       len_val = 5'd17;
                default: len_val = 5'($urandom_range(0, 31));
            endcase
            case (phase % 4)
                0:       mask_val = 16'h0000;
                1:       mask_val = 16'hFFFF;
                default: mask_val = 16'($urandom_range(0, 65535) & $urandom_range(0, 65535));
            endcase
            case (phase % 3)
                0:       start_val = '0;
                1:       start_val = '1 - $urandom_range(0, 40);
                default: start_val = {$urandom, $urandom};
            endcase
            if (phase % 5 == 4)
            begin
                low_val  = '1;
                high_val = '1;
            end
            else
            begin
                low_val  = {$urandom, $urandom};
                high_val = {$urandom, $urandom};
            end
            settle();
            write_reg(REG_PATTERN_LOW, low_val);
            write_reg(REG_PATTERN_HIGH, high_val);
            write_reg(REG_WILDCARD, mask_val);
            write_reg(REG_LENGTH, len_val);
            write_reg(REG_RANGE_START, start_val);
            if (phase == 0)
            begin
                // One-word ranges each owe a result, so the block backs up quickly.
                hold_request = 1'b1;
                repeat (40) send_byte(byte_t'($urandom_range(0, 255)), 1'b1, CHECK_PREDICT, '0);
                items_sent += 40;
            end
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE)
                send_range();
        end

        settle();
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
